/* hdl/masb_pkg.sv */
// Shared types and fixed field widths for the mux ADC scan buffer.
// No dependencies.
`timescale 1ns / 1ps

package masb_pkg;

   localparam int SAMPLE_IN_W = 10;
   localparam int CHAN_ID_W   = 5;
   localparam int SEL_W       = 4;
   localparam int INPUT_W     = 4;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 24;
   localparam int QUEUE_DEPTH = 3;

   localparam logic ACT_CONVERT = 1'b0;
   localparam logic ACT_READ    = 1'b1;

   typedef struct packed {
      logic                   mux_number;
      logic [SEL_W-1:0]       mux_select;
      logic                   start_conversion;
      logic                   data_available;
      logic [SAMPLE_IN_W-1:0] read_value;
   } rsp_word_type;

endpackage

/* hdl/mux_adc_scan_buffer.sv */
// Scan sequencer and channel buffer for ADC inputs behind analog muxes.
// Each accepted request word is registered in the p_*_ff stage, then pushed into the result queue.
// Throughput: one word per cycle while the queue has room; a three-word result queue absorbs stalls.
// Reset clears the scan state, read mask, order table and sample valid bits;
// unwritten buffer entries read as zero. No clearing pass is needed.
// Depends on masb_pkg.
`timescale 1ns / 1ps

module mux_adc_scan_buffer
   import masb_pkg::*;
#(
   parameter int CHANNELS    = 32,
   parameter int MUX_INPUTS  = 16,
   parameter int MUX_COUNT   = 2,
   parameter int SAMPLE_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [63:0]           csr_wr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // sample[9:0], channel_id[14:10]
   input  logic                  req_tuser,  // action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // read_value[9:0], data_available[10],
                                             // start_conversion[11], mux_select[15:12],
                                             // mux_number[16]
);

   localparam int FILL_W = $clog2(CHANNELS);
   localparam int MUX_W  = (MUX_COUNT > 1) ? $clog2(MUX_COUNT) : 1;
   localparam int PTR_W  = $clog2(QUEUE_DEPTH);

   logic                   accept;
   logic [SAMPLE_IN_W-1:0] req_sample;
   logic [CHAN_ID_W-1:0]   req_chan;
   logic                   chan_ok;
   logic [FILL_W-1:0]      chan_idx;
   logic [CHANNELS-1:0]    mask_upd;
   logic                   full;
   logic                   wr_en;
   logic                   start;

   logic [63:0]            order_ff;
   logic [FILL_W-1:0]      fill_ff,  fill_in;
   logic [INPUT_W-1:0]     input_ff, input_in;
   logic [MUX_W-1:0]       mux_ff,   mux_in;
   logic                   adc_ff,   adc_in;
   logic                   ready_ff, ready_in;
   logic [CHANNELS-1:0]    mask_ff,  mask_in;
   logic [CHANNELS-1:0]    valid_ff;

   logic [SAMPLE_BITS-1:0] store_mem [CHANNELS];
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   logic                   p_valid_ff;
   logic                   p_hit_ff;
   logic                   p_avail_ff;
   logic                   p_start_ff;
   logic [SEL_W-1:0]       p_sel_ff;
   logic                   p_mux_ff;

   rsp_word_type           push_word;
   rsp_word_type           queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       head_ff, tail_ff;
   logic [PTR_W:0]         count_ff;
   logic                   pop;

   assign req_sample = req_tdata[SAMPLE_IN_W-1:0];
   assign req_chan   = req_tdata[SAMPLE_IN_W +: CHAN_ID_W];
   assign chan_ok    = int'(req_chan) < CHANNELS;
   assign chan_idx   = FILL_W'(req_chan);
   assign mask_upd   = mask_ff | (CHANNELS'(1) << chan_idx);
   assign full       = fill_ff == FILL_W'(CHANNELS - 1);

   assign req_tready = (PTR_W+1)'(count_ff + (PTR_W+1)'(p_valid_ff))
                       < (PTR_W+1)'(QUEUE_DEPTH);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      fill_in  = fill_ff;
      input_in = input_ff;
      mux_in   = mux_ff;
      adc_in   = adc_ff;
      ready_in = ready_ff;
      mask_in  = mask_ff;
      wr_en    = 1'b0;
      start    = 1'b0;
      if (accept) begin
         if (req_tuser == ACT_CONVERT) begin
            if (!ready_ff) begin
               wr_en   = 1'b1;
               fill_in = full ? '0 : fill_ff + FILL_W'(1);
               if (input_ff == INPUT_W'(MUX_INPUTS - 1)) begin
                  input_in = '0;
                  mux_in   = (mux_ff == MUX_W'(MUX_COUNT - 1)) ? '0 : mux_ff + MUX_W'(1);
                  if (int'(mux_in) < 2) begin
                     adc_in = mux_in[0];
                  end
               end else begin
                  input_in = input_ff + INPUT_W'(1);
               end
               if (full) begin
                  ready_in = 1'b1;
               end
               start = !full;
            end
         end else begin
            if (chan_ok) begin
               if (mask_upd == {CHANNELS{1'b1}}) begin
                  mask_in  = '0;
                  ready_in = 1'b0;
                  start    = 1'b1;
               end else begin
                  mask_in = mask_upd;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff   <= '0;
         fill_ff    <= '0;
         input_ff   <= '0;
         mux_ff     <= '0;
         adc_ff     <= 1'b0;
         ready_ff   <= 1'b0;
         mask_ff    <= '0;
         valid_ff   <= '0;
         p_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            order_ff <= csr_wr_data;
         end
         fill_ff    <= fill_in;
         input_ff   <= input_in;
         mux_ff     <= mux_in;
         adc_ff     <= adc_in;
         ready_ff   <= ready_in;
         mask_ff    <= mask_in;
         p_valid_ff <= accept;
         if (wr_en) begin
            valid_ff[fill_ff] <= 1'b1;
         end
      end
   end

   // sample buffer: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[fill_ff] <= SAMPLE_BITS'(req_sample);
      end
      if (accept) begin
         rd_data_ff <= store_mem[chan_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p_hit_ff   <= (req_tuser == ACT_READ) && chan_ok && valid_ff[chan_idx];
         p_avail_ff <= ready_in;
         p_start_ff <= start;
         p_sel_ff   <= order_ff[{input_in, 2'b00} +: SEL_W];
         p_mux_ff   <= adc_in;
      end
   end

   always_comb begin
      push_word.read_value       = p_hit_ff ? SAMPLE_IN_W'(rd_data_ff) : '0;
      push_word.data_available   = p_avail_ff;
      push_word.start_conversion = p_start_ff;
      push_word.mux_select       = p_sel_ff;
      push_word.mux_number       = p_mux_ff;
   end

   // result queue
   assign rsp_tvalid = count_ff != '0;
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = RSP_DATA_W'(queue_ff[head_ff]);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (p_valid_ff) begin
            tail_ff <= (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
         end
         if (pop) begin
            head_ff <= (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
         end
         count_ff <= count_ff + (PTR_W+1)'(p_valid_ff) - (PTR_W+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (p_valid_ff) begin
         queue_ff[tail_ff] <= push_word;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff |-> count_ff < (PTR_W+1)'(QUEUE_DEPTH) || pop)
      else $error("result queue overflow");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      int'(fill_ff) < CHANNELS)
      else $error("fill index out of range");

   a_ready_fill: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> fill_ff == '0)
      else $error("scan ready with partial fill");

   a_start_avail: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff |-> !(p_start_ff && p_avail_ff))
      else $error("conversion requested while data available");

   a_ready_set: assert property (@(posedge clock) disable iff (reset)
      $rose(ready_ff) |-> $past(wr_en))
      else $error("scan ready without final conversion");

endmodule

/* verif/mux_adc_scan_checker.sv */
// Scoreboard for the mux ADC scan buffer: tracks the order table, sample store,
// scan position and read mask, predicts every result word and compares in order.
// Depends on masb_pkg.
`timescale 1ns / 1ps

module mux_adc_scan_checker
   import masb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [63:0]           csr_wr_data,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // sample[9:0], channel_id[14:10]
   input  logic                  req_tuser,   // action
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // read_value[9:0], data_available[10],
                                              // start_conversion[11], mux_select[15:12],
                                              // mux_number[16]
   output int                    errors,
   output int                    pending
);

   localparam int NUM_CHANNELS = 32;
   localparam int NUM_INPUTS   = 16;
   localparam int NUM_MUXES    = 2;
   localparam int WORD_W       = $bits(rsp_word_type);

   logic [63:0]            order_table;
   logic [SAMPLE_IN_W-1:0] sample_store [NUM_CHANNELS];
   int                     fill_idx;
   int                     cur_input;
   int                     cur_mux;
   logic                   scan_ready;
   logic [NUM_CHANNELS-1:0] read_mask;
   logic                   adc_pin;

   rsp_word_type expected_words [$];
   int fail_count = 0;
   int queued = 0;

   assign errors  = fail_count;
   assign pending = queued;

   task report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   task scan_step(input logic act, input logic [SAMPLE_IN_W-1:0] smp,
                  input logic [CHAN_ID_W-1:0] ch, output rsp_word_type w);
      logic                   start;
      logic [SAMPLE_IN_W-1:0] value;
      start = 1'b0;
      value = '0;
      if (act == ACT_CONVERT) begin
         // conversions arriving while a scan waits to be read are dropped
         if (!scan_ready) begin
            sample_store[fill_idx] = smp;
            fill_idx++;
            cur_input++;
            if (cur_input >= NUM_INPUTS) begin
               cur_input = 0;
               cur_mux++;
               if (cur_mux >= NUM_MUXES) cur_mux = 0;
               if (cur_mux < 2) adc_pin = cur_mux[0];
            end
            if (fill_idx >= NUM_CHANNELS) begin
               fill_idx   = 0;
               scan_ready = 1'b1;
            end else begin
               start = 1'b1;
            end
         end
      end else begin
         value         = sample_store[ch];
         read_mask[ch] = 1'b1;
         if (&read_mask) begin
            read_mask  = '0;
            scan_ready = 1'b0;
            start      = 1'b1;
         end
      end
      w.read_value       = value;
      w.data_available   = scan_ready;
      w.start_conversion = start;
      w.mux_select       = order_table[4*cur_input +: SEL_W];
      w.mux_number       = adc_pin;
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type got;
      if (reset) begin
         order_table = '0;
         for (int i = 0; i < NUM_CHANNELS; i++) sample_store[i] = '0;
         fill_idx   = 0;
         cur_input  = 0;
         cur_mux    = 0;
         scan_ready = 1'b0;
         read_mask  = '0;
         adc_pin    = 1'b0;
         expected_words.delete();
      end else begin
         if (csr_wr_en) order_table = csr_wr_data;
         if (req_tvalid && req_tready) begin
            scan_step(req_tuser, req_tdata[SAMPLE_IN_W-1:0],
                      req_tdata[SAMPLE_IN_W +: CHAN_ID_W], want);
            expected_words.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", int'(rsp_tdata), 0);
            end else begin
               want = expected_words.pop_front();
               got  = rsp_word_type'(rsp_tdata[WORD_W-1:0]);
               if (got.read_value !== want.read_value)
                  report_mismatch("read_value", int'(got.read_value),
                                  int'(want.read_value));
               if (got.data_available !== want.data_available)
                  report_mismatch("data_available", int'(got.data_available),
                                  int'(want.data_available));
               if (got.start_conversion !== want.start_conversion)
                  report_mismatch("start_conversion", int'(got.start_conversion),
                                  int'(want.start_conversion));
               if (got.mux_select !== want.mux_select)
                  report_mismatch("mux_select", int'(got.mux_select),
                                  int'(want.mux_select));
               if (got.mux_number !== want.mux_number)
                  report_mismatch("mux_number", int'(got.mux_number),
                                  int'(want.mux_number));
               if (rsp_tdata[RSP_DATA_W-1:WORD_W] !== '0)
                  report_mismatch("padding", int'(rsp_tdata[RSP_DATA_W-1:WORD_W]), 0);
            end
         end
      end
      queued = expected_words.size();
   end

endmodule

/* verif/mux_adc_scan_buffer_tb.sv */
// Top of the mux ADC scan buffer testbench: clock, reset, stimulus, stall
// patterns, watchdog and verdict. Depends on masb_pkg, mux_adc_scan_buffer
// and mux_adc_scan_checker.
`timescale 1ns / 1ps

module mux_adc_scan_buffer_tb;
   import masb_pkg::*;

   localparam int RSP_HOLD_CYCLES = 80;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int TARGET_WORDS    = 450;
   localparam int DRAIN_CYCLES    = 10;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [63:0]           csr_wr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // sample[9:0], channel_id[14:10]
   logic                  req_tuser;   // action
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // read_value[9:0], data_available[10],
                                       // start_conversion[11], mux_select[15:12],
                                       // mux_number[16]
   int fail_count;
   int pending;

   bit free_flow;
   bit hold_rsp;
   int useful_words;
   int idle_cycles;

   mux_adc_scan_buffer dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   mux_adc_scan_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .errors      (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (free_flow || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   // entered and left at a falling edge
   task send_word(input logic act, input logic [SAMPLE_IN_W-1:0] smp,
                  input logic [CHAN_ID_W-1:0] ch);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {1'b0, ch, smp};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task send_convert();
      send_word(ACT_CONVERT, SAMPLE_IN_W'($urandom_range(0, 1023)),
                CHAN_ID_W'($urandom_range(0, 31)));
   endtask

   task send_read(input logic [CHAN_ID_W-1:0] ch);
      send_word(ACT_READ, SAMPLE_IN_W'($urandom_range(0, 1023)), ch);
   endtask

   task write_order_table(input logic [63:0] value);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // result side
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
            rsp_tready <= 1'b1;
         end else if (!free_flow && $urandom_range(0, 99) < 3) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(8, 30)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= free_flow || ($urandom_range(0, 99) >= 25);
         end
      end
   end

   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      int          round_no;
      int          fill_n;
      int          j;
      int          tmp;
      int          order [32];
      logic [63:0] tbl;

      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = ACT_CONVERT;
      free_flow   = 1'b0;
      hold_rsp    = 1'b0;
      useful_words = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reads before any scan, with the reset order table
      send_read(5'd0);
      send_read(5'd31);
      write_order_table(64'hFEDC_BA98_7654_3210);
      send_word(ACT_CONVERT, 10'h000, 5'h1F);
      send_word(ACT_CONVERT, 10'h3FF, 5'h00);
      send_word(ACT_CONVERT, 10'h155, 5'h15);
      send_word(ACT_CONVERT, 10'h2AA, 5'h0A);
      send_word(ACT_READ, 10'h3FF, 5'd0);
      send_word(ACT_READ, 10'h000, 5'd1);
      send_word(ACT_READ, 10'h2AA, 5'd2);
      send_word(ACT_READ, 10'h155, 5'd3);
      send_read(5'd31);

      round_no = 0;
      while (useful_words < TARGET_WORDS) begin
         case (round_no % 4)
            0: tbl = '1;
            1: tbl = '0;
            2: tbl = {$urandom(), $urandom()};
            default: tbl = 64'h0123_4567_89AB_CDEF;
         endcase
         write_order_table(tbl);
         free_flow = (round_no % 3 == 2);
         if (round_no == 1 || round_no == 4) hold_rsp = 1'b1;

         // mostly complete scans, sometimes a partial one read out early
         fill_n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 31) : 32;
         for (int i = 0; i < fill_n; i++) begin
            if ($urandom_range(0, 15) == 0) begin
               send_read(CHAN_ID_W'($urandom_range(0, 31)));
               useful_words++;
            end
            send_convert();
            useful_words++;
         end
         repeat ($urandom_range(0, 2)) send_convert();

         for (int i = 0; i < 32; i++) order[i] = i;
         for (int i = 31; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
         end
         for (int i = 0; i < 32; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               send_read(CHAN_ID_W'($urandom_range(0, 31)));
               useful_words++;
            end
            if ($urandom_range(0, 19) == 0) send_convert();
            send_read(CHAN_ID_W'(order[i]));
            useful_words++;
         end
         round_no++;
      end

      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
